// ===== src/rcdg_pkg.sv =====
// ----------------------------------------------------------------------------
// rcdg_pkg
// Types and constants shared by the crop, downscale and gray conversion block.
// ----------------------------------------------------------------------------
package rcdg_pkg;

  // register file layout
  localparam int unsigned CFG_W       = 11;
  localparam int unsigned CFG_IDX_W   = 2;

  // position and accumulator widths
  localparam int unsigned POS_W       = 10;
  localparam int unsigned DEST_W      = 11;
  localparam int unsigned ACC_W       = 21;

  // clamp limit for every size register, and crop offset divisor (1 or 2)
  localparam int unsigned MAX_DIM      = 1024;
  localparam int unsigned CROP_DIVISOR = 2;

  // depth of the queue between selection and conversion
  localparam int unsigned QUEUE_DEPTH = 4;

  // register reset values
  localparam logic [CFG_W-1:0] IN_WIDTH_RST   = 11'd320;
  localparam logic [CFG_W-1:0] IN_HEIGHT_RST  = 11'd240;
  localparam logic [CFG_W-1:0] OUT_WIDTH_RST  = 11'd192;
  localparam logic [CFG_W-1:0] OUT_HEIGHT_RST = 11'd192;

  // gray offset
  localparam logic [7:0] GRAY_OFFSET = 8'h80;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_WIDTH   = 2'd0,
    CFG_IN_HEIGHT  = 2'd1,
    CFG_OUT_WIDTH  = 2'd2,
    CFG_OUT_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] pixel;
    logic        frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] gray;
    logic [POS_W-1:0]  out_col;
    logic [POS_W-1:0]  out_row;
    logic              end_of_row;
    logic              end_of_frame;
  } out_item_t;

  // a kept source pixel with its output position
  typedef struct packed {
    logic [15:0]      pixel;
    logic [POS_W-1:0] out_col;
    logic [POS_W-1:0] out_row;
    logic             end_of_row;
    logic             end_of_frame;
  } kept_t;

endpackage

// ===== src/rcdg_select.sv =====
// ----------------------------------------------------------------------------
// rcdg_select
// Front end: holds the size registers, tracks the source position and picks
// the pixels that land on the output grid, using add-only accumulators.
// ----------------------------------------------------------------------------
module rcdg_select (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  rcdg_pkg::cfg_idx_e         cfg_index_i,
  input  logic [rcdg_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  input  rcdg_pkg::in_item_t         in_item_i,
  output logic                       kept_valid_o,
  output rcdg_pkg::kept_t            kept_o
);
  import rcdg_pkg::*;

  localparam logic [12:0] MaxDim = 13'(MAX_DIM);

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = ({2'b00, v} > MaxDim) ? MaxDim[CFG_W-1:0] : v;
    return r;
  endfunction

  // size registers
  logic [CFG_W-1:0] in_width_q, in_height_q, out_width_q, out_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q   <= IN_WIDTH_RST;
      in_height_q  <= IN_HEIGHT_RST;
      out_width_q  <= OUT_WIDTH_RST;
      out_height_q <= OUT_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IN_WIDTH:   in_width_q   <= cfg_data_i;
        CFG_IN_HEIGHT:  in_height_q  <= cfg_data_i;
        CFG_OUT_WIDTH:  out_width_q  <= cfg_data_i;
        CFG_OUT_HEIGHT: out_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // position state
  logic [POS_W-1:0]  src_col_q, src_col_d;
  logic [ACC_W-1:0]  col_target_q, col_target_d, col_base_q, col_base_d;
  logic [ACC_W-1:0]  row_target_q, row_target_d, row_base_q, row_base_d;
  logic              row_taken_q, row_taken_d;
  logic [DEST_W-1:0] dest_col_q, dest_col_d, dest_row_q, dest_row_d;

  // state as seen by this pixel, after an optional frame restart
  logic [POS_W-1:0]  cur_src_col;
  logic [ACC_W-1:0]  cur_col_target, cur_col_base, cur_row_target, cur_row_base;
  logic              cur_row_taken;
  logic [DEST_W-1:0] cur_dest_col, cur_dest_row;

  logic [CFG_W-1:0]  w, h, ow, oh, ow_c, oh_c, crop;
  logic              active, in_crop, emit, eor, eof, row_end;
  logic [ACC_W:0]    col_lim;

  // restart and clamped sizes
  always_comb begin
    cur_src_col    = in_item_i.frame_start ? '0 : src_col_q;
    cur_col_target = in_item_i.frame_start ? '0 : col_target_q;
    cur_col_base   = in_item_i.frame_start ? '0 : col_base_q;
    cur_row_target = in_item_i.frame_start ? '0 : row_target_q;
    cur_row_base   = in_item_i.frame_start ? '0 : row_base_q;
    cur_row_taken  = in_item_i.frame_start ? 1'b1 : row_taken_q;
    cur_dest_col   = in_item_i.frame_start ? '0 : dest_col_q;
    cur_dest_row   = in_item_i.frame_start ? '0 : dest_row_q;

    w    = clamp_dim(in_width_q);
    h    = clamp_dim(in_height_q);
    ow_c = clamp_dim(out_width_q);
    oh_c = clamp_dim(out_height_q);
    ow   = (ow_c > h) ? h : ow_c;
    oh   = (oh_c > h) ? h : oh_c;

    active  = (w >= h) && (h != '0) && (ow != '0) && (oh != '0) && (cur_dest_row < oh);
    crop    = CFG_W'((w - h) / CROP_DIVISOR);
    in_crop = {1'b0, cur_src_col} >= crop;
    col_lim = {1'b0, cur_col_base} + (ACC_W+1)'(ow);
    emit    = active && in_crop && cur_row_taken && (cur_dest_col < ow) &&
              ({1'b0, cur_col_target} < col_lim);
    eor     = (cur_dest_col + 1'b1) == ow;
    eof     = eor && ((cur_dest_row + 1'b1) == oh);
    row_end = ({1'b0, cur_src_col} + 1'b1) >= w;
  end

  // next position state
  always_comb begin
    src_col_d    = cur_src_col;
    col_target_d = cur_col_target;
    col_base_d   = cur_col_base;
    row_target_d = cur_row_target;
    row_base_d   = cur_row_base;
    row_taken_d  = cur_row_taken;
    dest_col_d   = cur_dest_col;
    dest_row_d   = cur_dest_row;
    if (active) begin
      if (in_crop) begin
        if (emit) begin
          dest_col_d   = cur_dest_col + 1'b1;
          col_target_d = cur_col_target + ACC_W'(h);
          if (eor) begin
            dest_row_d   = cur_dest_row + 1'b1;
            row_target_d = cur_row_target + ACC_W'(h);
          end
        end
        col_base_d = cur_col_base + ACC_W'(ow);
      end
      if (row_end) begin
        src_col_d    = '0;
        row_base_d   = cur_row_base + ACC_W'(oh);
        dest_col_d   = '0;
        col_target_d = '0;
        col_base_d   = '0;
        row_taken_d  = (dest_row_d < oh) &&
                       ({1'b0, row_target_d} < ({1'b0, row_base_d} + (ACC_W+1)'(oh)));
      end else begin
        src_col_d = cur_src_col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q    <= '0;
      col_target_q <= '0;
      col_base_q   <= '0;
      row_target_q <= '0;
      row_base_q   <= '0;
      row_taken_q  <= 1'b1;
      dest_col_q   <= '0;
      dest_row_q   <= '0;
    end else if (in_valid_i) begin
      src_col_q    <= src_col_d;
      col_target_q <= col_target_d;
      col_base_q   <= col_base_d;
      row_target_q <= row_target_d;
      row_base_q   <= row_base_d;
      row_taken_q  <= row_taken_d;
      dest_col_q   <= dest_col_d;
      dest_row_q   <= dest_row_d;
    end
  end

  // kept pixel toward the queue
  assign kept_valid_o        = in_valid_i && emit;
  assign kept_o.pixel        = in_item_i.pixel;
  assign kept_o.out_col      = cur_dest_col[POS_W-1:0];
  assign kept_o.out_row      = cur_dest_row[POS_W-1:0];
  assign kept_o.end_of_row   = eor;
  assign kept_o.end_of_frame = eof;

  // a frame end is always a row end
  a_eof_implies_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_valid_o && kept_o.end_of_frame |-> kept_o.end_of_row)
    else $error("frame end without row end");

endmodule

// ===== src/rcdg_queue.sv =====
// ----------------------------------------------------------------------------
// rcdg_queue
// Short queue of kept pixels between the selection front end and the
// conversion back end.
// ----------------------------------------------------------------------------
module rcdg_queue #(
  parameter int unsigned DEPTH = rcdg_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  rcdg_pkg::kept_t wr_data_i,
  input  logic            rd_en_i,
  output rcdg_pkg::kept_t rd_data_o,
  output logic            full_o,
  output logic            empty_o
);
  import rcdg_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  kept_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  // pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_ptr_q];
  assign full_o    = (count_q == FullCnt);
  assign empty_o   = (count_q == '0);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !rd_en_i |-> !wr_en_i)
    else $error("write into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> !empty_o)
    else $error("read from empty queue");

endmodule

// ===== src/rcdg_convert.sv =====
// ----------------------------------------------------------------------------
// rcdg_convert
// Back end: turns a kept RGB565 pixel into a signed gray sample and holds it
// in the output register until it is taken.
// ----------------------------------------------------------------------------
module rcdg_convert (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  rcdg_pkg::kept_t     q_data_i,
  output logic                q_rd_o,
  input  logic                pop_i,
  output logic                empty_o,
  output rcdg_pkg::out_item_t out_item_o
);
  import rcdg_pkg::*;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic      load;
  logic [7:0] sum;

  // weighted sum 2r + 2g + b, then offset
  always_comb begin
    sum = {2'b00, q_data_i.pixel[15:11], 1'b0} + {1'b0, q_data_i.pixel[10:5], 1'b0} +
          {3'b000, q_data_i.pixel[4:0]};
    out_d.gray         = $signed(sum - GRAY_OFFSET);
    out_d.out_col      = q_data_i.out_col;
    out_d.out_row      = q_data_i.out_row;
    out_d.end_of_row   = q_data_i.end_of_row;
    out_d.end_of_frame = q_data_i.end_of_frame;
  end

  // refill the output register when it is free or being taken
  assign load        = !q_empty_i && (!out_valid_q || pop_i);
  assign q_rd_o      = load;
  assign out_valid_d = load ? 1'b1 : (pop_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  a_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty_i && !out_valid_q |=> out_valid_q)
    else $error("waiting request not moved to output register");

endmodule

// ===== src/rgb565_crop_downscale_gray_unit.sv =====
// ----------------------------------------------------------------------------
// rgb565_crop_downscale_gray_unit
// Crops the centered square of an RGB565 frame, downscales it by nearest
// neighbor and emits signed 8-bit gray samples with their output position.
// ----------------------------------------------------------------------------
// Usage:
//   Input pixels arrive in raster order; a request is taken when push is high
//   and full is low. frame_start on a request restarts the position tracking.
//   Results leave in order; the oldest one is on out_item_o while empty is
//   low and is taken when pop is high.
//   Size registers are written through cfg_we_i / cfg_index_i / cfg_data_i
//   while the block is idle; a write takes effect on the next pixel.
//   Throughput: one pixel per cycle while full is low. Each pixel is classified
//   combinationally by the add-and-compare logic of the selection front end.
//   A kept pixel is written into the queue when it is taken, then loaded into
//   the output register once that register is free or being taken.
//   Reset: sizes return to 320x240 in and 192x192 out, the position state
//   equals a frame start and the queue and output register are empty.
//   Stall: when pop stays low the output register holds, the queue fills
//   and full rises once QUEUE_DEPTH kept pixels wait behind the output
//   register.
// ----------------------------------------------------------------------------
module rgb565_crop_downscale_gray_unit #(
  parameter int unsigned QUEUE_DEPTH = rcdg_pkg::QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  rcdg_pkg::cfg_idx_e         cfg_index_i,
  input  logic [rcdg_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       push,
  output logic                       full,
  input  rcdg_pkg::in_item_t         in_item_i,
  input  logic                       pop,
  output logic                       empty,
  output rcdg_pkg::out_item_t        out_item_o
);
  import rcdg_pkg::*;

  logic  in_accept;
  logic  kept_valid;
  kept_t kept;
  logic  q_rd, q_empty;
  kept_t q_data;

  assign in_accept = push && !full;

  // selection front end
  rcdg_select u_select (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_accept),
    .in_item_i    (in_item_i),
    .kept_valid_o (kept_valid),
    .kept_o       (kept)
  );

  // decoupling queue
  rcdg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (kept_valid),
    .wr_data_i (kept),
    .rd_en_i   (q_rd),
    .rd_data_o (q_data),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  // conversion back end
  rcdg_convert u_convert (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (q_data),
    .q_rd_o     (q_rd),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_item_o (out_item_o)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the crop, nearest-neighbor downscale and gray conversion unit. A
// scoreboard class tracks the source position and selection accumulators per
// accepted pixel request and checks each gray sample against that prediction.
// Both queue sides idle at random, and the result side holds off for long
// stretches so the unit fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
  import rcdg_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned ITEM_COUNT    = 1900;

  // tracks frame position and selection, holds the gray samples still due
  class downscale_scoreboard;
    logic [CFG_W-1:0]  in_w_reg, in_h_reg, out_w_reg, out_h_reg;
    logic [POS_W-1:0]  col_pos, row_pos;
    logic [ACC_W-1:0]  col_goal, col_acc, row_goal, row_acc;
    bit                row_kept;
    logic [DEST_W-1:0] emit_col, emit_row;
    out_item_t         pending_samples[$];
    int unsigned       mismatches;
    int unsigned       samples_seen;

    function new();
      in_w_reg     = IN_WIDTH_RST;
      in_h_reg     = IN_HEIGHT_RST;
      out_w_reg    = OUT_WIDTH_RST;
      out_h_reg    = OUT_HEIGHT_RST;
      mismatches   = 0;
      samples_seen = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      col_pos  = '0;
      row_pos  = '0;
      col_goal = '0;
      col_acc  = '0;
      row_goal = '0;
      row_acc  = '0;
      row_kept = 1'b1;
      emit_col = '0;
      emit_row = '0;
    endfunction

    function void set_size(cfg_idx_e idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_IN_WIDTH:   in_w_reg = val;
        CFG_IN_HEIGHT:  in_h_reg = val;
        CFG_OUT_WIDTH:  out_w_reg = val;
        CFG_OUT_HEIGHT: out_h_reg = val;
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(logic [CFG_W-1:0] val);
      return (val > MAX_DIM) ? MAX_DIM : val;
    endfunction

    // advances the frame position; returns 0 when the unit ignores the pixel
    function bit note_pixel(in_item_t px);
      int unsigned w, h, ow, oh, crop, c, sum;
      bit          eor;
      out_item_t   smp;
      if (px.frame_start) restart_frame();
      w  = clamp_dim(in_w_reg);
      h  = clamp_dim(in_h_reg);
      ow = clamp_dim(out_w_reg);
      oh = clamp_dim(out_h_reg);
      if (ow > h) ow = h;
      if (oh > h) oh = h;
      if (w < h || h == 0 || ow == 0 || oh == 0 || emit_row >= oh) return 1'b0;
      crop = (w - h) / CROP_DIVISOR;
      c = col_pos;

      // inside the square: keep the pixel when the column accumulator says so
      if (c >= crop) begin
        if (row_kept && emit_col < ow && col_goal < col_acc + ow) begin
          sum = 2 * px.pixel[15:11] + 2 * px.pixel[10:5] + px.pixel[4:0];
          eor = (emit_col + 1 == ow);
          smp.gray         = 8'(sum - GRAY_OFFSET);
          smp.out_col      = emit_col[POS_W-1:0];
          smp.out_row      = emit_row[POS_W-1:0];
          smp.end_of_row   = eor;
          smp.end_of_frame = eor && (emit_row + 1 == oh);
          pending_samples.push_back(smp);
          emit_col = emit_col + 1'b1;
          col_goal = ACC_W'(col_goal + h);
          if (eor) begin
            emit_row = emit_row + 1'b1;
            row_goal = ACC_W'(row_goal + h);
          end
        end
        col_acc = ACC_W'(col_acc + ow);
      end

      // end of source row: decide whether the next row feeds an output row
      if (c + 1 >= w) begin
        col_pos  = '0;
        row_pos  = row_pos + 1'b1;
        row_acc  = ACC_W'(row_acc + oh);
        emit_col = '0;
        col_goal = '0;
        col_acc  = '0;
        row_kept = (emit_row < oh) && (row_goal < row_acc + oh);
      end else begin
        col_pos = POS_W'(c + 1);
      end
      return 1'b1;
    endfunction

    function void report_field(string name, int expv, int gotv);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, gotv);
      mismatches++;
    endfunction

    function void check_sample(out_item_t got);
      out_item_t want;
      samples_seen++;
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample, expected none, actual gray %0d col %0d row %0d",
                 $time, got.gray, got.out_col, got.out_row);
        mismatches++;
        return;
      end
      want = pending_samples.pop_front();
      if (got.gray !== want.gray) report_field("gray", want.gray, got.gray);
      if (got.out_col !== want.out_col) report_field("out_col", want.out_col, got.out_col);
      if (got.out_row !== want.out_row) report_field("out_row", want.out_row, got.out_row);
      if (got.end_of_row !== want.end_of_row)
        report_field("end_of_row", want.end_of_row, got.end_of_row);
      if (got.end_of_frame !== want.end_of_frame)
        report_field("end_of_frame", want.end_of_frame, got.end_of_frame);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  cfg_idx_e            cfg_index_i;
  logic [CFG_W-1:0]    cfg_data_i;
  logic                push;
  logic                full;
  in_item_t            in_item_i;
  logic                pop;
  logic                empty;
  out_item_t           out_item_o;

  downscale_scoreboard sb = new();
  bit                  send_calm;
  int unsigned         sent_items;

  rgb565_crop_downscale_gray_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .pop         (pop),
    .empty       (empty),
    .out_item_o  (out_item_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // offer one pixel request and wait until it is taken
  task automatic offer_pixel(input logic [15:0] pix, input bit start);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= '{pixel: pix, frame_start: start};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    void'(sb.note_pixel(in_item_i));
    sent_items++;
  endtask

  task automatic send_pixels(input int count, input bit start_first);
    for (int i = 0; i < count; i++) begin
      offer_pixel(16'($urandom_range(0, 16'hFFFF)), start_first && (i == 0));
    end
  endtask

  // wait for every due sample, then let in-flight work settle
  task automatic wait_idle();
    push <= 1'b0;
    while (sb.pending_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    sb.set_size(idx, val);
  endtask

  task automatic set_sizes(input logic [CFG_W-1:0] w, h, ow, oh);
    wait_idle();
    write_reg(CFG_IN_WIDTH, w);
    write_reg(CFG_IN_HEIGHT, h);
    write_reg(CFG_OUT_WIDTH, ow);
    write_reg(CFG_OUT_HEIGHT, oh);
    cfg_we_i <= 1'b0;
  endtask

  // result side: random pop gaps, calm stretches and long hold-offs
  initial begin : result_side
    int          gap;
    int unsigned next_hold;
    bit          recv_calm;
    next_hold = 40;
    recv_calm = 1'b0;
    pop <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (sb.samples_seen % 64 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      if (sb.samples_seen >= next_hold) begin
        gap = HOLD_CYCLES;
        next_hold += 400;
      end else begin
        gap = recv_calm ? 0 : $urandom_range(0, 11);
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      sb.check_sample(out_item_o);
    end
  end

  // run limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // stimulus
  initial begin : pixel_side
    logic [15:0] corner_pix[6];
    int          roll, w, h, ow, oh, kind, frame_len;
    corner_pix = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'h8410};
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_IN_WIDTH;
    cfg_data_i  <= '0;
    push        <= 1'b0;
    in_item_i   <= '0;
    send_calm   = 1'b0;
    sent_items  = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset sizes, no frame start after reset
    send_pixels(3, 1'b0);

    // upscale and oversize output clamped, color extremes, finished frame
    set_sizes(3, 2, 5, 2047);
    for (int i = 0; i < 6; i++) offer_pixel(corner_pix[i], i == 0);
    send_pixels(2, 1'b0);
    send_pixels(1, 1'b1);

    // narrow frame, then zero output width
    set_sizes(2, 3, 2, 2);
    send_pixels(3, 1'b1);
    set_sizes(4, 2, 0, 1);
    send_pixels(2, 1'b1);

    // sizes change in the middle of a frame
    set_sizes(4, 4, 2, 2);
    send_pixels(4, 1'b1);
    set_sizes(4, 4, 4, 2);
    send_pixels(4, 1'b0);

    // largest sizes: oversize input width, one full 1024-wide output row
    set_sizes(2047, 1020, 2047, 2047);
    send_pixels(16, 1'b1);
    set_sizes(2047, 2047, 2047, 3);
    send_calm = 1'b1;
    send_pixels(1028, 1'b1);
    send_calm = 1'b0;
    set_sizes(1023, 1024, 8, 8);
    send_pixels(8, 1'b1);
    set_sizes(0, 1, 1, 1);
    send_pixels(4, 1'b1);
    set_sizes(5, 0, 1, 1);
    send_pixels(4, 1'b1);

    // random phases of mostly well-formed small frames
    while (sent_items < ITEM_COUNT) begin
      roll = $urandom_range(0, 19);
      h  = $urandom_range(1, 8);
      w  = h + $urandom_range(0, 8);
      ow = $urandom_range(1, h + 2);
      oh = $urandom_range(1, h + 2);
      if (roll == 0) begin
        w = $urandom_range(0, h - 1);
      end else if (roll == 1) begin
        case ($urandom_range(0, 2))
          0: h = 0;
          1: ow = 0;
          default: oh = 0;
        endcase
      end else if (roll == 2) begin
        ow = $urandom_range(1000, 2047);
      end
      set_sizes(CFG_W'(w), CFG_W'(h), CFG_W'(ow), CFG_W'(oh));
      send_calm = ($urandom_range(0, 3) == 0);
      frame_len = (w * h < 6) ? 6 : w * h;
      repeat ($urandom_range(1, 4)) begin
        kind = $urandom_range(0, 9);
        case (kind)
          6: send_pixels(frame_len + $urandom_range(1, 6), 1'b1);
          7: send_pixels($urandom_range(1, frame_len), 1'b1);
          8: begin
            repeat ($urandom_range(1, frame_len)) begin
              offer_pixel(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3) == 0);
            end
          end
          9: send_pixels(frame_len, 1'b0);
          default: send_pixels(frame_len, 1'b1);
        endcase
      end
    end

    // drain and report
    wait_idle();
    if (sb.mismatches == 0 && sb.pending_samples.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== rgb565_crop_downscale_gray_unit.f =====
src/rcdg_pkg.sv
src/rcdg_select.sv
src/rcdg_queue.sv
src/rcdg_convert.sv
src/rgb565_crop_downscale_gray_unit.sv
test/tb.sv
